// ----- rtl/core/four_gamete_greedy_site_mask_defines.svh -----
// Assertion macros for the four-gamete site masking block.
`ifndef FOUR_GAMETE_GREEDY_SITE_MASK_DEFINES_SVH
`define FOUR_GAMETE_GREEDY_SITE_MASK_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FGM_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/fgm_pkg.sv -----
// Package with shared types and constants of the four-gamete site masking block.
package fgm_pkg;
  localparam int unsigned GAMETE_LIMIT = 4;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned MASK_W = 64;
  localparam int unsigned CNT_W = 6;
  localparam logic CFG_IDX_SEQS = 1'b0;
  localparam logic CFG_IDX_SITES = 1'b1;

  typedef struct packed {
    logic [1:0] base;
    logic       last;
  } fgm_in_t;

  typedef struct packed {
    logic [MASK_W-1:0] kept_mask;
    logic [CNT_W-1:0]  removed_count;
    logic              error;
  } fgm_out_t;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b00000001,
    ST_PASS  = 8'b00000010,
    ST_NEXT  = 8'b00000100,
    ST_READ  = 8'b00001000,
    ST_FOLD  = 8'b00010000,
    ST_JUDGE = 8'b00100000,
    ST_MASK  = 8'b01000000,
    ST_DONE  = 8'b10000000
  } fgm_state_t;
endpackage

// ----- rtl/core/fgm_if.sv -----
// Valid/ready channel interface carrying one payload.
interface fgm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/four_gamete_greedy_site_mask.sv -----
// Top level of the greedy four-gamete site masking block.
// Bases load one per cycle, while the block is in its load state, into an
// on-chip memory of MAX_SEQUENCES*MAX_SITES entries. The request with last set
// starts the greedy search, during which the block takes no request. A pass
// visits every kept site i and every other kept site j; each such ordered pair
// is scanned through one memory read port with two reads per sequence. A pair
// whose bases show more than four combinations ends the search with the error
// flag set; otherwise passes repeat once per masked site plus a final pass.
// The result waits in an output register; the next alignment may load
// meanwhile, and a new result waits until the old one is taken.
`include "four_gamete_greedy_site_mask_defines.svh"
module four_gamete_greedy_site_mask
  import fgm_pkg::*;
#(
  parameter int unsigned MAX_SEQUENCES = 64,
  parameter int unsigned MAX_SITES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  fgm_if.sink              in_ch,
  fgm_if.source            out_ch
);
  localparam int unsigned DEPTH = MAX_SEQUENCES * MAX_SITES;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned QW = $clog2(MAX_SEQUENCES + 1);
  localparam int unsigned SW = $clog2(MAX_SITES);
  localparam int unsigned SNW = SW + 1;

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_r;

  fgm_state_t state_r;
  logic [CFG_W-1:0] nseq_r, nsite_r;
  logic [AW-1:0] lpos_r;
  logic [QW-1:0] nq;
  logic [SNW-1:0] ns;
  logic [SNW-1:0] si_r, sj_r;
  logic [SW-1:0] best_r;
  logic [QW-1:0] sq_r;
  logic          phase_r;
  logic [1:0]    bi_r;
  logic [15:0]   seen_r;
  logic [AW-1:0] base_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] bestc_r;
  logic [MAX_SITES-1:0] kept_r;
  logic [CNT_W-1:0] masked_r;
  logic err_r;
  logic out_v_r;
  fgm_out_t out_r;
  logic [AW-1:0] rd_addr;
  logic [4:0] pop;
  logic in_fire;
  logic out_fire;
  logic out_load;
  logic site_end;

  assign nq = (nseq_r == '0) ? QW'(1) :
              ({{32-CFG_W{1'b0}}, nseq_r} > MAX_SEQUENCES) ? QW'(MAX_SEQUENCES) : QW'(nseq_r);
  assign ns = (nsite_r == '0) ? SNW'(1) :
              ({{32-CFG_W{1'b0}}, nsite_r} > MAX_SITES) ? SNW'(MAX_SITES) : SNW'(nsite_r);

  assign in_ch.ready = (state_r == ST_LOAD);
  assign out_ch.valid = out_v_r;
  assign out_ch.data = out_r;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign out_load = (state_r == ST_DONE) && (!out_v_r || out_ch.ready);

  always_comb begin
    pop = '0;
    for (int k = 0; k < 16; k++) begin
      pop = pop + 5'(seen_r[k]);
    end
  end

  assign site_end = (sj_r >= ns) || !kept_r[si_r[SW-1:0]];
  assign rd_addr = base_r + AW'(phase_r ? sj_r : si_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[lpos_r] <= in_ch.data.base;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      nseq_r <= CFG_W'(64);
      nsite_r <= CFG_W'(64);
      lpos_r <= '0;
      kept_r <= '1;
      masked_r <= '0;
      err_r <= 1'b0;
      cnt_r <= '0;
      seen_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_SEQS) nseq_r <= cfg_data;
        else nsite_r <= cfg_data;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (in_ch.data.last) begin
              lpos_r <= '0;
              for (int k = 0; k < MAX_SITES; k++) begin
                kept_r[k] <= (k < int'(ns));
              end
              masked_r <= '0;
              err_r <= 1'b0;
              state_r <= ST_PASS;
            end else begin
              lpos_r <= (lpos_r == AW'(DEPTH - 1)) ? '0 : lpos_r + 1'b1;
            end
          end
        end
        ST_PASS: begin
          si_r <= '0;
          sj_r <= '0;
          cnt_r <= '0;
          best_r <= '0;
          bestc_r <= '0;
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          if (site_end) begin
            if (cnt_r > bestc_r) begin
              bestc_r <= cnt_r;
              best_r <= si_r[SW-1:0];
            end
            cnt_r <= '0;
            sj_r <= '0;
            si_r <= si_r + 1'b1;
            if (si_r + 1'b1 >= ns) state_r <= ST_MASK;
          end else if (sj_r == si_r || !kept_r[sj_r[SW-1:0]]) begin
            sj_r <= sj_r + 1'b1;
          end else begin
            seen_r <= '0;
            sq_r <= '0;
            phase_r <= 1'b0;
            base_r <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          // Site i is read, then site j; the pair is recorded in the following cycle.
          if (phase_r) begin
            bi_r <= rd_r;
            phase_r <= 1'b0;
            base_r <= base_r + AW'(ns);
            sq_r <= sq_r + 1'b1;
            if (sq_r == nq - 1'b1) state_r <= ST_FOLD;
          end else begin
            phase_r <= 1'b1;
            if (sq_r != '0) seen_r[{bi_r, rd_r}] <= 1'b1;
          end
        end
        ST_FOLD: begin
          seen_r[{bi_r, rd_r}] <= 1'b1;
          state_r <= ST_JUDGE;
        end
        ST_JUDGE: begin
          if (pop > 5'(GAMETE_LIMIT)) begin
            err_r <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            if (pop == 5'(GAMETE_LIMIT)) cnt_r <= cnt_r + 1'b1;
            sj_r <= sj_r + 1'b1;
            state_r <= ST_NEXT;
          end
        end
        ST_MASK: begin
          if (bestc_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            kept_r[best_r] <= 1'b0;
            masked_r <= masked_r + 1'b1;
            state_r <= ST_PASS;
          end
        end
        ST_DONE: begin
          if (out_load) state_r <= ST_LOAD;
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
      out_r.kept_mask <= MASK_W'(kept_r);
      out_r.removed_count <= masked_r;
      out_r.error <= err_r;
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  `FGM_ASSERT(a_no_in_when_busy, clk, rst_n, state_r != ST_LOAD, !in_ch.ready)
  `FGM_ASSERT_NEXT(a_done_gives_out, clk, rst_n, state_r == ST_DONE && !out_v_r, out_v_r)
  `FGM_ASSERT_NEXT(a_out_held, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
  `FGM_ASSERT(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
endmodule
